/* hdl/sait_pkg.sv */
// Shared widths, codes and beat types of the swept axis interval test.
package sait_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EPS_WIDTH  = DATA_WIDTH - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH);

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_CONTACT = 2'd1;
    localparam logic [1:0] VERDICT_ENTRY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_ENTRY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_START_EXIT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_EPS   = CFG_IDX_W'(3);

    localparam logic [DATA_WIDTH-1:0] FX_ONE = DATA_WIDTH'(1) << FRAC_BITS;

    typedef struct packed {
        logic                         start_req;
        logic signed [DATA_WIDTH-1:0] lo_a;
        logic signed [DATA_WIDTH-1:0] hi_a;
        logic signed [DATA_WIDTH-1:0] lo_b;
        logic signed [DATA_WIDTH-1:0] hi_b;
        logic signed [DATA_WIDTH-1:0] rel_speed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                   verdict;
        logic signed [DATA_WIDTH-1:0] entry_out;
        logic signed [DATA_WIDTH-1:0] exit_out;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
    } t_div_ctl;

endpackage

/* hdl/sait_div_lane.sv */
// Radix-2 serial fixed-point divider lane with saturating signed result.
module sait_div_lane (
    input  logic                                   i_clk,
    input  sait_pkg::t_div_ctl                     i_ctl,
    input  logic signed [sait_pkg::DATA_WIDTH-1:0] i_num_a,
    input  logic signed [sait_pkg::DATA_WIDTH-1:0] i_num_b,
    input  logic                                   i_den_neg,
    input  logic        [sait_pkg::DATA_WIDTH-1:0] i_den_mag,
    output logic signed [sait_pkg::DATA_WIDTH-1:0] o_quot
);
    import sait_pkg::*;

    localparam logic [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  r_neg;
    logic                  r_ovf;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_shift;
    logic [DATA_WIDTH-1:0] r_quot;

    logic [DATA_WIDTH:0]   d_ab;
    logic [DATA_WIDTH-1:0] d_ba;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] trial;
    logic                  fits;
    logic                  q_big;

    // numerator a - b as sign and magnitude, both differences side by side
    assign d_ab  = {i_num_a[DATA_WIDTH-1], i_num_a} - {i_num_b[DATA_WIDTH-1], i_num_b};
    assign d_ba  = i_num_b - i_num_a;
    assign n_mag = d_ab[DATA_WIDTH] ? d_ba : d_ab[DATA_WIDTH-1:0];

    assign trial = {r_rem[DATA_WIDTH-2:0], r_shift[DATA_WIDTH-1]};
    assign fits  = (trial >= i_den_mag);
    assign q_big = r_quot[DATA_WIDTH-1] & (|r_quot[DATA_WIDTH-2:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg   <= d_ab[DATA_WIDTH] ^ i_den_neg;
            r_ovf   <= 1'b0;
            // top fraction-width bits seed the remainder; the rest shift in a bit a cycle
            r_rem   <= n_mag >> (DATA_WIDTH - FRAC_BITS);
            r_shift <= n_mag << FRAC_BITS;
            r_quot  <= '0;
        end else if (i_ctl.check) begin
            // quotient reaches 2^DATA_WIDTH: saturate regardless of the low bits
            r_ovf <= (r_rem >= i_den_mag);
        end else if (i_ctl.step) begin
            if (fits) begin
                r_rem <= trial - i_den_mag;
            end else begin
                r_rem <= trial;
            end
            r_shift <= r_shift << 1;
            r_quot  <= {r_quot[DATA_WIDTH-2:0], fits};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_ovf || r_quot[DATA_WIDTH-1]) ? QMAX : r_quot;
        end else begin
            o_quot = (r_ovf || q_big) ? QMIN : DATA_WIDTH'(-r_quot);
        end
    end

endmodule

/* hdl/swept_axis_interval_test_core.sv */
// Top level of the swept axis interval test: one projection axis per beat.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one axis: the
// two projection intervals, the relative speed and a start flag that reloads
// the running entry and exit times from the start registers first. Output
// channel (o_out_valid / i_out_ready, payload o_out) gives one beat per axis:
// the verdict and the entry and exit times after that axis.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes time_limit,
// start_entry_time, start_exit_time and speed_epsilon by index 0..3; other
// indexes are dropped. Write it only while the block is idle.
// A new axis is taken only in the idle state, so the block cannot take the next axis
// until the current one has left its last step. Both contact times come from two
// radix-2 divider lanes that run side by side, one quotient bit per cycle,
// plus an overflow check ahead of the bits.
// The result sits in an output register, so the next axis is taken while a
// result still waits; a stalled receiver holds the block in its last step
// until the output register frees up. Synchronous reset clears the registers
// to their reset values, the entry time to zero and the exit time to one.
module swept_axis_interval_test_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  sait_pkg::t_in_item                     i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output sait_pkg::t_out_item                    o_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [sait_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [sait_pkg::DATA_WIDTH-1:0] i_cfg_data
);
    import sait_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_MERGE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_cnt;
    t_in_item                     r_item;
    logic                         r_below, r_above, r_sneg, r_szero, r_moving;
    logic [DATA_WIDTH-1:0]        r_smag;
    logic signed [DATA_WIDTH-1:0] r_t0, r_t1;
    logic                         r_t0_gt, r_t1_lt;
    logic signed [DATA_WIDTH-1:0] r_entry, r_exit;
    logic signed [DATA_WIDTH-1:0] r_limit, r_start_entry, r_start_exit;
    logic [EPS_WIDTH-1:0]         r_eps;
    t_out_item                    r_out;
    logic                         r_out_valid;

    logic                         in_fire, out_free, done_fire, away, use_hl;
    t_div_ctl                     div_ctl;
    logic signed [DATA_WIDTH-1:0] a0, b0, a1, b1, q0, q1;
    logic signed [DATA_WIDTH-1:0] e_time, x_time, n_entry, n_exit;
    logic [1:0]                   n_verdict;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign done_fire = (r_state == ST_DONE) && out_free;

    // pick numerator pairs: t0 is the near gap, t1 the far gap
    assign use_hl = (r_below || r_above) ? r_below : !r_sneg;
    assign a0 = r_below ? r_item.lo_a : r_item.hi_a;
    assign b0 = r_below ? r_item.hi_b : r_item.lo_b;
    assign a1 = use_hl ? r_item.hi_a : r_item.lo_a;
    assign b1 = use_hl ? r_item.lo_b : r_item.hi_b;

    assign div_ctl.load  = (r_state == ST_LOAD);
    assign div_ctl.check = (r_state == ST_DIV) && (r_cnt == '0);
    assign div_ctl.step  = (r_state == ST_DIV) && (r_cnt != '0);

    sait_div_lane u_lane_t0 (
        .i_clk     (i_clk),
        .i_ctl     (div_ctl),
        .i_num_a   (a0),
        .i_num_b   (b0),
        .i_den_neg (r_sneg),
        .i_den_mag (r_smag),
        .o_quot    (q0)
    );

    sait_div_lane u_lane_t1 (
        .i_clk     (i_clk),
        .i_ctl     (div_ctl),
        .i_num_a   (a1),
        .i_num_b   (b1),
        .i_den_neg (r_sneg),
        .i_den_mag (r_smag),
        .o_quot    (q1)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == CNT_LAST) n_state = ST_FIX;
            ST_FIX:   n_state = ST_MERGE;
            ST_MERGE: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // final decision for the axis
    always_comb begin
        e_time    = r_t0_gt ? r_t0 : r_entry;
        x_time    = r_t1_lt ? r_t1 : r_exit;
        away      = r_below ? (r_sneg || r_szero) : !r_sneg;
        n_verdict = VERDICT_CONTACT;
        n_entry   = r_entry;
        n_exit    = r_exit;
        if (r_below || r_above) begin
            if (away) begin
                n_verdict = VERDICT_NONE;
            end else if ((e_time > r_limit) || (e_time > x_time)) begin
                n_verdict = VERDICT_NONE;
            end else begin
                n_verdict = r_t0_gt ? VERDICT_ENTRY : VERDICT_CONTACT;
                n_entry   = e_time;
                n_exit    = x_time;
            end
        end else if (r_moving) begin
            // exit shrinks even when the axis fails
            n_exit = x_time;
            if (r_entry > x_time) begin
                n_verdict = VERDICT_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_entry       <= '0;
            r_exit        <= FX_ONE;
            r_limit       <= FX_ONE;
            r_start_entry <= '0;
            r_start_exit  <= FX_ONE;
            r_eps         <= EPS_WIDTH'(1);
        end else begin
            r_state <= n_state;

            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end

            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire && i_in.start_req) begin
                r_entry <= r_start_entry;
                r_exit  <= r_start_exit;
            end else if (done_fire) begin
                r_entry <= n_entry;
                r_exit  <= n_exit;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TIME_LIMIT:  r_limit       <= i_cfg_data;
                    REG_START_ENTRY: r_start_entry <= i_cfg_data;
                    REG_START_EXIT:  r_start_exit  <= i_cfg_data;
                    REG_SPEED_EPS:   r_eps         <= i_cfg_data[EPS_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item  <= i_in;
            r_below <= (i_in.hi_b < i_in.lo_a);
            r_above <= (i_in.hi_a < i_in.lo_b);
            r_sneg  <= i_in.rel_speed[DATA_WIDTH-1];
            r_szero <= (i_in.rel_speed == '0);
        end
        if (r_state == ST_LOAD) begin
            r_smag <= r_sneg ? DATA_WIDTH'(-r_item.rel_speed) : r_item.rel_speed;
        end
        if (r_state == ST_FIX) begin
            r_t0     <= q0;
            r_t1     <= q1;
            r_moving <= (r_smag > {1'b0, r_eps});
        end
        if (r_state == ST_MERGE) begin
            r_t0_gt <= (r_t0 > r_entry);
            r_t1_lt <= (r_t1 < r_exit);
        end
        if (done_fire) begin
            r_out.verdict   <= n_verdict;
            r_out.entry_out <= n_entry;
            r_out.exit_out  <= n_exit;
        end
    end

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_LOAD))
        else $error("accepted beat did not start a division");

    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CNT_LAST))
        else $error("divider step count ran past the quotient width");

    a_result_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result beat raised outside the decision step");

    a_entry_verdict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.verdict == VERDICT_ENTRY)) |->
            ((o_out.entry_out <= o_out.exit_out) && (o_out.entry_out <= r_limit)))
        else $error("entry verdict with entry time past exit or limit");

endmodule

/* bench/swept_axis_interval_test_core_tb.sv */
// Self-checking bench for the swept axis interval test core: directed and random axes.
`timescale 1ns / 1ps

module swept_axis_interval_test_core_tb;
    import sait_pkg::*;

    // Running entry/exit interval predictor plus the queue of result beats it implies.
    class axis_scoreboard;
        logic signed [DATA_WIDTH-1:0] limit_q;
        logic signed [DATA_WIDTH-1:0] start_entry_q;
        logic signed [DATA_WIDTH-1:0] start_exit_q;
        logic        [EPS_WIDTH-1:0]  eps_q;
        logic signed [DATA_WIDTH-1:0] entry_q;
        logic signed [DATA_WIDTH-1:0] exit_q;
        t_out_item                    contact_q[$];
        int                           errors;
        int                           checked;

        function new();
            limit_q       = FX_ONE;
            start_entry_q = '0;
            start_exit_q  = FX_ONE;
            eps_q         = EPS_WIDTH'(1);
            entry_q       = '0;
            exit_q        = FX_ONE;
            errors        = 0;
            checked       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] data);
            case (idx)
                REG_TIME_LIMIT:  limit_q = data;
                REG_START_ENTRY: start_entry_q = data;
                REG_START_EXIT:  start_exit_q = data;
                REG_SPEED_EPS:   eps_q = data[EPS_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return contact_q.size();
        endfunction

        // a - b as sign and magnitude
        static function longint unsigned separation(longint a, longint b, output bit neg);
            neg = a < b;
            return neg ? longint'(b - a) : longint'(a - b);
        endfunction

        // num * 2^FRAC_BITS / den on magnitudes, truncated, saturated to the data range
        static function longint time_quot(bit nneg, longint unsigned nmag, longint den);
            longint unsigned lim, dmag, mag, rem;
            longint          maxv, minv;
            bit              dneg, neg, sat;
            lim  = 64'd1 << (DATA_WIDTH - 1);
            maxv = longint'(lim) - 1;
            minv = -longint'(lim);
            dneg = den < 0;
            dmag = dneg ? 64'(-den) : 64'(den);
            neg  = nneg ^ dneg;
            if (dmag == 0) begin
                if (nmag == 0) return 0;
                return nneg ? minv : maxv;
            end
            mag = nmag / dmag;
            rem = nmag % dmag;
            sat = mag > lim;
            for (int i = 0; i < FRAC_BITS && !sat; i++) begin
                if (mag > lim / 2) sat = 1'b1;
                mag = mag << 1;
                rem = rem << 1;
                if (rem >= dmag) begin
                    rem = rem - dmag;
                    mag = mag | 64'd1;
                end
                if (mag > lim) sat = 1'b1;
            end
            if (!neg) return (sat || mag > lim - 1) ? maxv : longint'(mag);
            if (sat) return minv;
            return -longint'(mag);
        endfunction

        function void note_axis(t_in_item ax);
            longint          la, ha, lb, hb, spd, ent, ext, lim, t0, t1, e, x;
            longint unsigned m0, m1, smag;
            bit              n0, n1, below, away;
            t_out_item       res;
            if (ax.start_req) begin
                entry_q = start_entry_q;
                exit_q  = start_exit_q;
            end
            la  = longint'(ax.lo_a);
            ha  = longint'(ax.hi_a);
            lb  = longint'(ax.lo_b);
            hb  = longint'(ax.hi_b);
            spd = longint'(ax.rel_speed);
            ent = longint'(entry_q);
            ext = longint'(exit_q);
            lim = longint'(limit_q);
            res.verdict = VERDICT_CONTACT;
            if (hb < la || ha < lb) begin
                below = hb < la;
                away  = below ? (spd <= 0) : (spd >= 0);
                if (away) begin
                    res.verdict = VERDICT_NONE;
                end else begin
                    if (below) begin
                        m0 = separation(la, hb, n0);
                        m1 = separation(ha, lb, n1);
                    end else begin
                        m0 = separation(ha, lb, n0);
                        m1 = separation(la, hb, n1);
                    end
                    t0 = time_quot(n0, m0, spd);
                    t1 = time_quot(n1, m1, spd);
                    e  = t0 > ent ? t0 : ent;
                    x  = t1 < ext ? t1 : ext;
                    if (e > lim || e > x) begin
                        res.verdict = VERDICT_NONE;
                    end else begin
                        res.verdict = (t0 > ent) ? VERDICT_ENTRY : VERDICT_CONTACT;
                        entry_q = DATA_WIDTH'(e);
                        exit_q  = DATA_WIDTH'(x);
                    end
                end
            end else begin
                smag = spd < 0 ? 64'(-spd) : 64'(spd);
                if (smag > eps_q) begin
                    if (spd > 0) m1 = separation(ha, lb, n1);
                    else         m1 = separation(la, hb, n1);
                    t1 = time_quot(n1, m1, spd);
                    // exit shrinks even when the axis then fails
                    if (t1 < ext) ext = t1;
                    exit_q = DATA_WIDTH'(ext);
                    if (ent > ext) res.verdict = VERDICT_NONE;
                end
            end
            res.entry_out = entry_q;
            res.exit_out  = exit_q;
            contact_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (contact_q.size() == 0) begin
                $error("result beat with nothing expected: verdict %0d entry %h exit %h",
                       got.verdict, got.entry_out, got.exit_out);
                errors++;
                return;
            end
            want = contact_q.pop_front();
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.entry_out !== want.entry_out) begin
                $error("entry_out: expected %h, got %h", want.entry_out, got.entry_out);
                errors++;
            end
            if (got.exit_out !== want.exit_out) begin
                $error("exit_out: expected %h, got %h", want.exit_out, got.exit_out);
                errors++;
            end
        endfunction
    endclass

    localparam int     DRAIN_CYCLES = 2 * (DATA_WIDTH + 6);
    localparam int     CYCLE_LIMIT  = 2_000_000;
    localparam int     NUM_PHASES   = 8;
    localparam int     PHASE_ITEMS  = 200;
    localparam longint FXL          = longint'(1) << FRAC_BITS;
    localparam longint MAXV         = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint MINV         = -(longint'(1) << (DATA_WIDTH - 1));
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = REG_SPEED_EPS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_FREE  = '1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_WIDTH-1:0] i_cfg_data  = '0;

    axis_scoreboard sb = new();
    int             cycle_count = 0;
    int             stall_pct   = 20;
    bit             send_idle   = 1'b1;
    int             axes_sent   = 0;

    swept_axis_interval_test_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    // mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // speed that closes a gap of sep in a random time up to 2.0
    function automatic longint approach_speed(longint sep);
        longint when, s;
        when = rand_between(1, 2 * FXL);
        s    = (sep * FXL) / when;
        if (s < 1) s = 1;
        if (s > MAXV) s = MAXV;
        return s;
    endfunction

    function automatic t_in_item make_axis(bit st, longint la, longint ha, longint lb,
                                           longint hb, longint spd);
        t_in_item ax;
        ax.start_req = st;
        ax.lo_a      = DATA_WIDTH'(la);
        ax.hi_a      = DATA_WIDTH'(ha);
        ax.lo_b      = DATA_WIDTH'(lb);
        ax.hi_b      = DATA_WIDTH'(hb);
        ax.rel_speed = DATA_WIDTH'(spd);
        return ax;
    endfunction

    task automatic send_axis(input t_in_item ax);
        i_in       <= ax;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_axis(ax);
        axes_sent++;
    endtask

    task automatic pause_sender();
        if (send_idle && $urandom_range(0, 99) < 40) begin
            i_in_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // drop valid unless a pause already did
    task automatic drop_valid();
        if (i_in_valid) i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stalls at the phase's rate
    initial begin : out_ready_drive
        int hold;
        bit rdy;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                    rdy  = 1'b0;
                    hold = idle_len() - 1;
                end else begin
                    rdy  = 1'b1;
                    hold = $urandom_range(0, 5);
                end
                i_out_ready <= rdy;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("swept_axis_interval_test_core: mismatch");
        $finish;
    end

    initial begin : main_seq
        t_in_item              directed[$];
        t_in_item              ax;
        int                    n, j, seq_len, kind, r;
        longint                base, sep, wa, wb, off, spd, tmp;
        logic [DATA_WIDTH-1:0] lim_v, se_v, sx_v, ep_v;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed axes under reset settings: limit 1.0, entry 0, exit 1.0, eps 1 lsb
        directed.push_back(make_axis(1, 0, FXL, -3 * FXL, -2 * FXL, 0));
        directed.push_back(make_axis(0, 0, FXL, -3 * FXL, -2 * FXL, -FXL));
        directed.push_back(make_axis(1, 0, FXL, -FXL, -FXL / 2, 2 * FXL));
        directed.push_back(make_axis(0, 0, FXL, -FXL, -FXL / 2, 4 * FXL));
        directed.push_back(make_axis(1, 0, FXL, 2 * FXL, 3 * FXL, -4 * FXL));
        directed.push_back(make_axis(0, 0, FXL, 2 * FXL, 3 * FXL, 0));
        directed.push_back(make_axis(0, 0, FXL, 2 * FXL, 3 * FXL, FXL));
        // entry beyond the time limit
        directed.push_back(make_axis(1, 0, FXL, -5 * FXL, -3 * FXL, FXL));
        // entry past the shrunken exit
        directed.push_back(make_axis(1, 0, FXL, -FXL, -FXL / 2, 4 * FXL));
        directed.push_back(make_axis(0, 0, FXL, -2 * FXL, -3 * FXL / 4, FXL));
        // overlap: still, at epsilon, just above epsilon, moving both ways
        directed.push_back(make_axis(1, 0, 2 * FXL, FXL, 3 * FXL, 0));
        directed.push_back(make_axis(0, 0, 2 * FXL, FXL, 3 * FXL, 1));
        directed.push_back(make_axis(0, 0, 2 * FXL, FXL, 3 * FXL, -1));
        directed.push_back(make_axis(0, 0, 2 * FXL, FXL, 3 * FXL, 2));
        directed.push_back(make_axis(0, 0, 2 * FXL, FXL, 3 * FXL, 4 * FXL));
        // exit shrinks below the entry: axis fails but exit is kept
        directed.push_back(make_axis(1, 0, FXL, -FXL, -FXL / 2, FXL));
        directed.push_back(make_axis(0, 0, 2 * FXL, FXL, 3 * FXL, -8 * FXL));
        // saturated quotients, both signs
        directed.push_back(make_axis(1, MAXV, MINV, MINV, MINV, 1));
        directed.push_back(make_axis(1, MAXV, MINV, MAXV, 0, 1));
        // reversed intervals and extreme speeds
        directed.push_back(make_axis(0, FXL, -FXL, 0, 0, 3 * FXL));
        directed.push_back(make_axis(1, 0, FXL, -FXL, -1, MINV));
        directed.push_back(make_axis(0, 0, FXL, 0, FXL, MINV));
        directed.push_back(make_axis(0, MINV, MAXV, MINV, MAXV, MAXV));
        directed.push_back(make_axis(1, MINV, MINV, MAXV, MAXV, MINV));
        foreach (directed[k]) begin
            send_axis(directed[k]);
            pause_sender();
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drop_valid();
            wait_drained();
            case (ph)
                0: begin
                    lim_v = DATA_WIDTH'(MAXV); se_v = DATA_WIDTH'(MINV);
                    sx_v  = DATA_WIDTH'(MAXV); ep_v = '0;
                end
                1: begin
                    lim_v = DATA_WIDTH'(MINV); se_v = DATA_WIDTH'(MAXV);
                    sx_v  = DATA_WIDTH'(MINV); ep_v = '1;
                end
                2: begin
                    lim_v = FX_ONE; se_v = '0; sx_v = FX_ONE; ep_v = DATA_WIDTH'(1);
                end
                3: begin
                    lim_v = FX_ONE >> 1; se_v = '0; sx_v = FX_ONE << 1; ep_v = 32'h100;
                end
                NUM_PHASES - 1: begin
                    lim_v = $urandom; se_v = $urandom; sx_v = $urandom; ep_v = $urandom;
                end
                default: begin
                    lim_v = DATA_WIDTH'(rand_between(0, 2 * FXL));
                    se_v  = DATA_WIDTH'(-rand_between(0, FXL / 4));
                    sx_v  = DATA_WIDTH'(rand_between(FXL / 2, 4 * FXL));
                    ep_v  = DATA_WIDTH'(rand_between(0, 1024));
                    ep_v[DATA_WIDTH-1] = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(REG_TIME_LIMIT, lim_v);
            write_reg(REG_START_ENTRY, se_v);
            write_reg(REG_START_EXIT, sx_v);
            write_reg(REG_SPEED_EPS, ep_v);
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_FREE, REG_LAST_FREE)), $urandom);
            i_cfg_valid <= 1'b0;

            // one phase runs flat out on both sides
            send_idle = (ph != 2);
            if (ph == 2) stall_pct = 0;
            else         stall_pct = 10 * $urandom_range(1, 6);

            n = 0;
            while (n < PHASE_ITEMS) begin
                seq_len = $urandom_range(1, 5);
                for (j = 0; j < seq_len && n < PHASE_ITEMS; j++) begin
                    kind = $urandom_range(0, 9);
                    base = rand_between(-(64'sd1 << 28), 64'sd1 << 28);
                    wa   = rand_between(0, 64'sd1 << 20);
                    wb   = rand_between(0, 64'sd1 << 20);
                    sep  = rand_between(1, 64'sd1 << 18);
                    r    = $urandom_range(0, 99);
                    if (kind <= 2) begin
                        // B below A, mostly closing in
                        spd = (r < 15) ? -rand_between(0, 64'sd1 << 20) : approach_speed(sep);
                        ax  = make_axis(j == 0, base, base + wa, base - sep - wb, base - sep,
                                        spd);
                    end else if (kind <= 5) begin
                        spd = (r < 15) ? rand_between(0, 64'sd1 << 20) : -approach_speed(sep);
                        ax  = make_axis(j == 0, base, base + wa, base + wa + sep,
                                        base + wa + sep + wb, spd);
                    end else if (kind <= 8) begin
                        off = rand_between(-wb, wa);
                        if (r < 30) spd = rand_between(-3, 3);
                        else        spd = approach_speed(rand_between(1, 64'sd1 << 20));
                        if ($urandom_range(0, 1)) spd = -spd;
                        ax  = make_axis(j == 0, base, base + wa, base + off, base + off + wb,
                                        spd);
                    end else begin
                        ax = make_axis(1'($urandom_range(0, 1)), $signed($urandom),
                                       $signed($urandom), $signed($urandom),
                                       $signed($urandom), $signed($urandom));
                    end
                    if (kind <= 8 && $urandom_range(0, 99) < 10) begin
                        tmp = longint'(ax.lo_a);
                        ax.lo_a = ax.hi_a;
                        ax.hi_a = DATA_WIDTH'(tmp);
                    end
                    if (j != 0 && kind <= 8 && $urandom_range(0, 99) < 5) ax.start_req = 1'b1;
                    send_axis(ax);
                    pause_sender();
                    n++;
                    // hold the sender until every result is back
                    if (ph == 4 && n == PHASE_ITEMS / 2) begin
                        drop_valid();
                        wait_drained();
                    end
                end
            end
        end

        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d axes across %0d register settings, %0d result beats compared.",
                 axes_sent, NUM_PHASES + 1, sb.checked);
        $display("Exercised approach and retreat, entry limits, exit shrink, still overlaps,");
        $display("saturated quotients, reversed intervals and random noise with stalls.");
        if (sb.errors == 0)
            $display("swept_axis_interval_test_core: match");
        else
            $display("swept_axis_interval_test_core: mismatch");
        $finish;
    end

endmodule
